@@ src/ppt_pkg.sv @@
`timescale 1ns / 1ps
package ppt_pkg;

   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int PAIR_W = 65;
   localparam int SUM_W  = 66;
   localparam int MAG_W  = 64;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSFORM = 1'b1;

   localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [MAG_W-1:0]         mag_type;

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic                wzero;
      logic                sat_und;
      logic [WORD_W-1:0]   und_x;
      logic [WORD_W-1:0]   und_y;
      logic [WORD_W-1:0]   val_z;
   } side_type;

   // clip a magnitude to the signed 32-bit range; result is {sat, value}
   function automatic logic [WORD_W:0] clip_encode(input logic neg, input mag_type mag);
      logic [WORD_W:0] r;
      if (!neg && mag > MAG_W'(POS_LIMIT)) begin
         r = {1'b1, POS_LIMIT};
      end else if (neg && mag > MAG_W'(NEG_LIMIT)) begin
         r = {1'b1, NEG_LIMIT};
      end else if (neg) begin
         r = {1'b0, WORD_W'(0) - mag[WORD_W-1:0]};
      end else begin
         r = {1'b0, mag[WORD_W-1:0]};
      end
      return r;
   endfunction

endpackage

@@ src/ppt_mac.sv @@
`timescale 1ns / 1ps
module ppt_mac import ppt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     en,
   input  word_type pt_x,
   input  word_type pt_y,
   input  word_type pt_z,
   input  word_type matrix [16],
   output sum_type  col_sum [4]
);

   logic signed [PROD_W-1:0] prod_ff  [4][3];
   word_type                 trans_ff [4];
   logic signed [PAIR_W-1:0] pa_ff    [4];
   logic signed [PAIR_W-1:0] pb_ff    [4];
   sum_type                  sum_ff   [4];

   for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [PAIR_W-1:0] tx;
      assign tx = PAIR_W'(trans_ff[c]) <<< FRAC_BITS;

      always_ff @(posedge clock) begin
         if (en) begin
            // products
            prod_ff[c][0] <= pt_x * matrix[c];
            prod_ff[c][1] <= pt_y * matrix[4 + c];
            prod_ff[c][2] <= pt_z * matrix[8 + c];
            trans_ff[c]   <= matrix[12 + c];
            // pair sums
            pa_ff[c] <= PAIR_W'(prod_ff[c][0]) + PAIR_W'(prod_ff[c][1]);
            pb_ff[c] <= PAIR_W'(prod_ff[c][2]) + tx;
            // column total
            sum_ff[c] <= SUM_W'(pa_ff[c]) + SUM_W'(pb_ff[c]);
         end
      end

      assign col_sum[c] = sum_ff[c];
   end

endmodule

@@ src/ppt_div.sv @@
`timescale 1ns / 1ps
module ppt_div import ppt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              en,
   input  mag_type           num,
   input  mag_type           den,
   output logic [WORD_W-1:0] quo,
   output logic              ovf
);

   localparam int STEPS = WORD_W;
   localparam int SH    = WORD_W - FRAC_BITS;

   mag_type           rem_ff [0:STEPS];
   mag_type           den_ff [0:STEPS];
   logic [WORD_W-1:0] low_ff [0:STEPS];
   logic [WORD_W-1:0] q_ff   [0:STEPS];
   logic              ovf_ff [0:STEPS];

   mag_type rem0;
   assign rem0 = num >> SH;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0;
         den_ff[0] <= den;
         low_ff[0] <= num[WORD_W-1:0] << FRAC_BITS;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (rem0 >= den);
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;
      assign trial = {rem_ff[k-1], low_ff[k-1][WORD_W-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= {low_ff[k-1][WORD_W-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][WORD_W-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[STEPS];
   assign ovf = ovf_ff[STEPS];

endmodule

@@ src/projective_point_transform.sv @@
`timescale 1ns / 1ps
// Projective point transform: a stored 4x4 row-vector matrix applied to a
// 3-D point, then x and y divided by the homogeneous w.
// Input channel (req_*): opcode 0 writes matrix entry req_entry_index with
// req_entry_value (row*4+column, row 3 is translation) and gives no result;
// opcode 1 sends point (x, y, z) for transform and gives one result.
// Result channel (rsp_*): out_x, out_y (divided by w unless w is zero),
// out_z (never divided), w_was_zero and saturated, all Q16.16 by default.
// Pipeline: the transfer edge loads the input register, then three
// multiply/add stages, one magnitude stage, 33 divider stages (an overflow
// check, then one quotient bit per stage) and the output register.
// Throughput: one item per cycle while req_stall is low, set by the fully
// pipelined multipliers and the bit-per-stage restoring divider.
// Reset clears the matrix to zero and drops all items in flight.
// When the receiver stalls, the output register holds and a skid register
// absorbs the one item still arriving; the whole pipeline then freezes and
// req_stall rises until the skid register drains. Nothing is lost or
// repeated. A load issued after a transform never affects that transform.
module projective_point_transform import ppt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [3:0]               req_entry_index,
   input  logic signed [WORD_W-1:0] req_entry_value,
   input  logic signed [WORD_W-1:0] req_point_x,
   input  logic signed [WORD_W-1:0] req_point_y,
   input  logic signed [WORD_W-1:0] req_point_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_out_x,
   output logic signed [WORD_W-1:0] rsp_out_y,
   output logic signed [WORD_W-1:0] rsp_out_z,
   output logic                     rsp_w_was_zero,
   output logic                     rsp_saturated
);

   localparam int DIV_LAT = WORD_W + 1;

   logic en;
   logic skid_full_ff;

   // whole pipeline advances unless the skid register is occupied
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // matrix store and input register
   word_type matrix_ff [16];
   word_type pt_x_ff, pt_y_ff, pt_z_ff;
   logic     in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= '0;
         end
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid && (req_opcode == OP_TRANSFORM);
         if (req_valid && (req_opcode == OP_LOAD)) begin
            matrix_ff[req_entry_index] <= req_entry_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_x_ff <= req_point_x;
         pt_y_ff <= req_point_y;
         pt_z_ff <= req_point_z;
      end
   end

   // multiply and accumulate: three stages
   sum_type col_sum [4];
   logic [2:0] mac_valid_ff;

   ppt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock   (clock),
      .en      (en),
      .pt_x    (pt_x_ff),
      .pt_y    (pt_y_ff),
      .pt_z    (pt_z_ff),
      .matrix  (matrix_ff),
      .col_sum (col_sum)
   );

   // sign and magnitude of each exact column sum
   mag_type mag_x_ff, mag_y_ff, mag_z_ff, mag_w_ff;
   logic    neg_x_ff, neg_y_ff, neg_z_ff, neg_w_ff;
   logic    mag_valid_ff;
   sum_type nx, ny, nz, nw;

   assign nx = -col_sum[0];
   assign ny = -col_sum[1];
   assign nz = -col_sum[2];
   assign nw = -col_sum[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_valid_ff <= '0;
         mag_valid_ff <= 1'b0;
      end else if (en) begin
         mac_valid_ff <= {mac_valid_ff[1:0], in_valid_ff};
         mag_valid_ff <= mac_valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_x_ff <= col_sum[0][SUM_W-1];
         neg_y_ff <= col_sum[1][SUM_W-1];
         neg_z_ff <= col_sum[2][SUM_W-1];
         neg_w_ff <= col_sum[3][SUM_W-1];
         mag_x_ff <= col_sum[0][SUM_W-1] ? nx[MAG_W-1:0] : col_sum[0][MAG_W-1:0];
         mag_y_ff <= col_sum[1][SUM_W-1] ? ny[MAG_W-1:0] : col_sum[1][MAG_W-1:0];
         mag_z_ff <= col_sum[2][SUM_W-1] ? nz[MAG_W-1:0] : col_sum[2][MAG_W-1:0];
         mag_w_ff <= col_sum[3][SUM_W-1] ? nw[MAG_W-1:0] : col_sum[3][MAG_W-1:0];
      end
   end

   // dividers for x and y, sharing the w magnitude
   logic [WORD_W-1:0] quo_x, quo_y;
   logic              ovf_x, ovf_y;

   ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (mag_x_ff),
      .den   (mag_w_ff),
      .quo   (quo_x),
      .ovf   (ovf_x)
   );

   ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (mag_y_ff),
      .den   (mag_w_ff),
      .quo   (quo_y),
      .ovf   (ovf_y)
   );

   // side line: undivided results and flags, aligned with the dividers
   side_type          side_ff [DIV_LAT];
   logic [DIV_LAT-1:0] side_valid_ff;
   side_type          side_in;
   logic [WORD_W:0]   cx, cy, cz;
   logic              wz;

   assign wz = (mag_w_ff == '0);
   assign cx = clip_encode(neg_x_ff, mag_x_ff >> FRAC_BITS);
   assign cy = clip_encode(neg_y_ff, mag_y_ff >> FRAC_BITS);
   assign cz = clip_encode(neg_z_ff, mag_z_ff >> FRAC_BITS);

   always_comb begin
      side_in.neg_x   = neg_x_ff ^ neg_w_ff;
      side_in.neg_y   = neg_y_ff ^ neg_w_ff;
      side_in.wzero   = wz;
      side_in.und_x   = cx[WORD_W-1:0];
      side_in.und_y   = cy[WORD_W-1:0];
      side_in.val_z   = cz[WORD_W-1:0];
      side_in.sat_und = cz[WORD_W] | (wz & (cx[WORD_W] | cy[WORD_W]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_valid_ff <= '0;
      end else if (en) begin
         side_valid_ff <= {side_valid_ff[DIV_LAT-2:0], mag_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // final select and clip
   side_type          tail;
   logic [WORD_W:0]   dx, dy;
   logic [WORD_W-1:0] fin_x, fin_y;
   logic              fin_sat;
   logic              pipe_valid;

   assign tail       = side_ff[DIV_LAT-1];
   assign pipe_valid = side_valid_ff[DIV_LAT-1];

   always_comb begin
      dx = ovf_x ? {1'b1, (tail.neg_x ? NEG_LIMIT : POS_LIMIT)}
                 : clip_encode(tail.neg_x, MAG_W'(quo_x));
      dy = ovf_y ? {1'b1, (tail.neg_y ? NEG_LIMIT : POS_LIMIT)}
                 : clip_encode(tail.neg_y, MAG_W'(quo_y));
      fin_x   = tail.wzero ? tail.und_x : dx[WORD_W-1:0];
      fin_y   = tail.wzero ? tail.und_y : dy[WORD_W-1:0];
      fin_sat = tail.sat_und | (!tail.wzero & (dx[WORD_W] | dy[WORD_W]));
   end

   // output register plus skid register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic              rsp_wz_ff, rsp_sat_ff;
   logic [WORD_W-1:0] skid_x_ff, skid_y_ff, skid_z_ff;
   logic              skid_wz_ff, skid_sat_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (out_free) begin
         // take from skid first, else from the pipeline
         rsp_valid_ff <= skid_full_ff || pipe_valid;
         skid_full_ff <= 1'b0;
      end else if (pipe_valid && en) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_full_ff) begin
            rsp_x_ff   <= skid_x_ff;
            rsp_y_ff   <= skid_y_ff;
            rsp_z_ff   <= skid_z_ff;
            rsp_wz_ff  <= skid_wz_ff;
            rsp_sat_ff <= skid_sat_ff;
         end else begin
            rsp_x_ff   <= fin_x;
            rsp_y_ff   <= fin_y;
            rsp_z_ff   <= tail.val_z;
            rsp_wz_ff  <= tail.wzero;
            rsp_sat_ff <= fin_sat;
         end
      end else if (pipe_valid && en) begin
         skid_x_ff   <= fin_x;
         skid_y_ff   <= fin_y;
         skid_z_ff   <= tail.val_z;
         skid_wz_ff  <= tail.wzero;
         skid_sat_ff <= fin_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_z      = rsp_z_ff;
   assign rsp_w_was_zero = rsp_wz_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
